// ----- src/xalu_pkg.sv -----
// Shared types and constants for the 8086-style ALU with status flags.
`timescale 1ns / 1ps
package xalu_pkg;

  // Operation codes as they arrive on the request channel
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_OR   = 4'd1,
    OP_ADC  = 4'd2,
    OP_SBB  = 4'd3,
    OP_AND  = 4'd4,
    OP_SUB  = 4'd5,
    OP_XOR  = 4'd6,
    OP_CMP  = 4'd7,
    OP_TEST = 4'd8,
    OP_NOT  = 4'd9,
    OP_NEG  = 4'd10,
    OP_SHL  = 4'd11,
    OP_SHR  = 4'd12
  } opcode_e;

  // Execution class picked by the front end
  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_LOGIC,
    K_NOT,
    K_SHL,
    K_SHR,
    K_NOP
  } kind_e;

  // Bitwise function for the logic class
  typedef enum logic [1:0] {
    LG_AND,
    LG_OR,
    LG_XOR
  } logic_op_e;

  localparam int unsigned DataW    = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned QueueDep = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDep);
  localparam int unsigned QueueCntW = $clog2(QueueDep + 1);

  // Kept status flags
  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

  // Classified request, ready for the back end
  typedef struct packed {
    kind_e              kind;
    logic_op_e          lop;
    logic               use_carry;
    logic               write_back;
    logic               wide;
    logic [DataW-1:0]   opa;
    logic [DataW-1:0]   opb;
    logic [CountW-1:0]  count;
  } dec_t;

endpackage

// ----- src/x86_alu_with_flags.sv -----
// Top level of the 8086-style ALU with status flags.
//
// Requests arrive on the in_valid_i / in_ready_o channel: operation, width,
// destination and source. Each request gives one result on the
// out_valid_o / out_ready_i channel: result value, write-back mark and the
// six status flags as they stand after the operation.
// A request accepted at a clock edge sits in the queue and, with the output
// register free, goes through the execution unit into the output register at
// the next edge, where its result turns valid.
// Throughput is one request per cycle while the receiver keeps out_ready_i
// high, set by the execution unit, whose adder reads the carry flag written
// by the request just before it.
// The two-entry queue lets the front end keep taking requests while the
// output is stalled; in_ready_o drops only when the queue is full, which
// happens only after the receiver has held out_ready_i low.
// Reset clears the flags to zero and empties the queue and output register.
`timescale 1ns / 1ps
module x86_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  operation_i,
  input  logic        wide_i,
  input  logic [15:0] dst_value_i,
  input  logic [15:0] src_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_value_o,
  output logic        write_back_o,
  output logic        overflow_flag_o,
  output logic        sign_flag_o,
  output logic        zero_flag_o,
  output logic        aux_flag_o,
  output logic        parity_flag_o,
  output logic        carry_flag_o
);

  logic           push;
  xalu_pkg::dec_t push_data;
  logic           queue_ready;
  logic           head_valid;
  xalu_pkg::dec_t head;
  logic           pop;

  xalu_front u_front (
    .operation_i   (operation_i),
    .wide_i        (wide_i),
    .dst_value_i   (dst_value_i),
    .src_value_i   (src_value_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .push_o        (push),
    .push_data_o   (push_data),
    .queue_ready_i (queue_ready)
  );

  xalu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (queue_ready),
    .valid_o     (head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  xalu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .result_value_o  (result_value_o),
    .write_back_o    (write_back_o),
    .overflow_flag_o (overflow_flag_o),
    .sign_flag_o     (sign_flag_o),
    .zero_flag_o     (zero_flag_o),
    .aux_flag_o      (aux_flag_o),
    .parity_flag_o   (parity_flag_o),
    .carry_flag_o    (carry_flag_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule

// ----- src/xalu_front.sv -----
// Front end: takes requests and classifies them into execution classes.
`timescale 1ns / 1ps
module xalu_front (
  input  logic [3:0]               operation_i,
  input  logic                     wide_i,
  input  logic [15:0]              dst_value_i,
  input  logic [15:0]              src_value_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     push_o,
  output xalu_pkg::dec_t           push_data_o,
  input  logic                     queue_ready_i
);

  logic [xalu_pkg::DataW-1:0] mask;
  logic [xalu_pkg::DataW-1:0] d_m;
  logic [xalu_pkg::DataW-1:0] s_m;

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i && queue_ready_i;

  // Operands cut to the selected width
  assign mask = wide_i ? 16'hFFFF : 16'h00FF;
  assign d_m  = dst_value_i & mask;
  assign s_m  = src_value_i & mask;

  // Decode
  always_comb begin
    push_data_o            = '0;
    push_data_o.wide       = wide_i;
    push_data_o.opa        = d_m;
    push_data_o.opb        = s_m;
    push_data_o.count      = src_value_i[xalu_pkg::CountW-1:0];
    push_data_o.write_back = 1'b1;
    push_data_o.lop        = xalu_pkg::LG_AND;
    push_data_o.use_carry  = 1'b0;
    push_data_o.kind       = xalu_pkg::K_NOP;
    unique case (xalu_pkg::opcode_e'(operation_i))
      xalu_pkg::OP_ADD: push_data_o.kind = xalu_pkg::K_ADD;
      xalu_pkg::OP_ADC: begin
        push_data_o.kind      = xalu_pkg::K_ADD;
        push_data_o.use_carry = 1'b1;
      end
      xalu_pkg::OP_SUB: push_data_o.kind = xalu_pkg::K_SUB;
      xalu_pkg::OP_SBB: begin
        push_data_o.kind      = xalu_pkg::K_SUB;
        push_data_o.use_carry = 1'b1;
      end
      xalu_pkg::OP_CMP: begin
        push_data_o.kind       = xalu_pkg::K_SUB;
        push_data_o.write_back = 1'b0;
      end
      xalu_pkg::OP_NEG: begin
        // flags of 0 minus the operand
        push_data_o.kind = xalu_pkg::K_SUB;
        push_data_o.opa  = '0;
        push_data_o.opb  = d_m;
      end
      xalu_pkg::OP_AND: push_data_o.kind = xalu_pkg::K_LOGIC;
      xalu_pkg::OP_TEST: begin
        push_data_o.kind       = xalu_pkg::K_LOGIC;
        push_data_o.write_back = 1'b0;
      end
      xalu_pkg::OP_OR: begin
        push_data_o.kind = xalu_pkg::K_LOGIC;
        push_data_o.lop  = xalu_pkg::LG_OR;
      end
      xalu_pkg::OP_XOR: begin
        push_data_o.kind = xalu_pkg::K_LOGIC;
        push_data_o.lop  = xalu_pkg::LG_XOR;
      end
      xalu_pkg::OP_NOT: push_data_o.kind = xalu_pkg::K_NOT;
      xalu_pkg::OP_SHL: push_data_o.kind = xalu_pkg::K_SHL;
      xalu_pkg::OP_SHR: push_data_o.kind = xalu_pkg::K_SHR;
      default: begin
        // unused codes pass the destination through, no write back
        push_data_o.kind       = xalu_pkg::K_NOP;
        push_data_o.write_back = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/xalu_queue.sv -----
// Short queue of classified requests between front and back end.
`timescale 1ns / 1ps
module xalu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xalu_pkg::dec_t push_data_i,
  output logic           ready_o,
  output logic           valid_o,
  output xalu_pkg::dec_t head_o,
  input  logic           pop_i
);

  xalu_pkg::dec_t                   slot_q [xalu_pkg::QueueDep];
  logic [xalu_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [xalu_pkg::QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [xalu_pkg::QueueCntW-1:0]   count_q, count_d;

  assign ready_o = (count_q != xalu_pkg::QueueCntW'(xalu_pkg::QueueDep));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == xalu_pkg::QueuePtrW'(xalu_pkg::QueueDep - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == xalu_pkg::QueuePtrW'(xalu_pkg::QueueDep - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/xalu_back.sv -----
// Back end: adder, logic unit, shifter, flag register and output register.
`timescale 1ns / 1ps
module xalu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  xalu_pkg::dec_t head_i,
  output logic           pop_o,
  output logic [15:0]    result_value_o,
  output logic           write_back_o,
  output logic           overflow_flag_o,
  output logic           sign_flag_o,
  output logic           zero_flag_o,
  output logic           aux_flag_o,
  output logic           parity_flag_o,
  output logic           carry_flag_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  xalu_pkg::flags_t           flags_q, flags_d;
  logic [15:0]                result_q, result_d;
  logic                       wb_q;
  logic                       out_valid_q;
  logic [15:0]                mask;
  logic [15:0]                a, b, r;
  logic [16:0]                sum, diff, shl_v, shr_v;
  logic                       cin;
  logic                       szp;

  assign a    = head_i.opa;
  assign b    = head_i.opb;
  assign mask = head_i.wide ? 16'hFFFF : 16'h00FF;
  assign cin  = head_i.use_carry & flags_q.cf;

  // One adder, one subtractor and both shifters
  assign sum   = {1'b0, a} + {1'b0, b} + {16'b0, cin};
  assign diff  = {1'b0, a} - {1'b0, b} - {16'b0, cin};
  assign shl_v = {1'b0, a} << head_i.count;
  assign shr_v = {a, 1'b0} >> head_i.count;

  // Output register moves when empty or being taken
  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  // Result and next flags
  always_comb begin
    r       = a;
    flags_d = flags_q;
    szp     = 1'b0;
    case (head_i.kind)
      xalu_pkg::K_ADD: begin
        r          = sum[15:0] & mask;
        flags_d.cf = head_i.wide ? sum[16] : sum[8];
        flags_d.of = head_i.wide ? (~(a[15] ^ b[15]) & (a[15] ^ r[15]))
                                 : (~(a[7] ^ b[7]) & (a[7] ^ r[7]));
        flags_d.af = a[4] ^ b[4] ^ r[4];
        szp        = 1'b1;
      end
      xalu_pkg::K_SUB: begin
        r          = diff[15:0] & mask;
        flags_d.cf = diff[16];
        flags_d.of = head_i.wide ? ((a[15] ^ b[15]) & (a[15] ^ r[15]))
                                 : ((a[7] ^ b[7]) & (a[7] ^ r[7]));
        flags_d.af = a[4] ^ b[4] ^ r[4];
        szp        = 1'b1;
      end
      xalu_pkg::K_LOGIC: begin
        case (head_i.lop)
          xalu_pkg::LG_OR:  r = a | b;
          xalu_pkg::LG_XOR: r = a ^ b;
          default:          r = a & b;
        endcase
        flags_d.cf = 1'b0;
        flags_d.of = 1'b0;
        szp        = 1'b1;
      end
      xalu_pkg::K_NOT: r = ~a & mask;
      xalu_pkg::K_SHL: begin
        // count of zero leaves result and flags alone
        if (head_i.count != '0) begin
          r          = shl_v[15:0] & mask;
          flags_d.cf = head_i.wide ? shl_v[16] : shl_v[8];
          flags_d.of = head_i.wide ? (a[15] ^ r[15]) : (a[7] ^ r[7]);
          szp        = 1'b1;
        end
      end
      xalu_pkg::K_SHR: begin
        if (head_i.count != '0) begin
          r          = shr_v[16:1];
          flags_d.cf = shr_v[0];
          flags_d.of = head_i.wide ? (a[15] ^ r[15]) : (a[7] ^ r[7]);
          szp        = 1'b1;
        end
      end
      default: r = a;
    endcase
    if (szp) begin
      flags_d.sf = head_i.wide ? r[15] : r[7];
      flags_d.zf = (r == '0);
      flags_d.pf = ~^r[7:0];
    end
    result_d = r;
  end

  // Flag register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        flags_q <= flags_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
      wb_q     <= head_i.write_back;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_value_o  = result_q;
  assign write_back_o    = wb_q;
  assign overflow_flag_o = flags_q.of;
  assign sign_flag_o     = flags_q.sf;
  assign zero_flag_o     = flags_q.zf;
  assign aux_flag_o      = flags_q.af;
  assign parity_flag_o   = flags_q.pf;
  assign carry_flag_o    = flags_q.cf;

endmodule

// ----- src/xalu_checker.sv -----
// Port-level checks for the ALU, bound to the top level.
`timescale 1ns / 1ps
module xalu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] result_value_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_value_o))
    else $error("result changed while stalled");

  // With the output empty, a new result follows a taken request through the queue and then the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching request");

  // The queue fills only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request side blocked with output empty");

endmodule

bind x86_alu_with_flags xalu_checker u_xalu_checker (.*);
